// ===== src/shuffled_lcg_random_generator_assert.svh =====
// Assertion helpers for the RTL.
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_ASSERT_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define SLRG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SLRG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/slrg_pkg.sv =====
`timescale 1ns / 1ps

package slrg_pkg;

   localparam int DATA_W       = 31;
   localparam int TABLE_SIZE   = 32;
   localparam int WARMUP_STEPS = 8;
   localparam int INIT_STEPS   = TABLE_SIZE + WARMUP_STEPS;
   localparam int IDX_W        = $clog2(TABLE_SIZE);
   localparam int CNT_W        = $clog2(INIT_STEPS + 1);
   localparam int PROD_W       = 2 * DATA_W;

   localparam logic [DATA_W-1:0] MODULUS      = 31'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] DEFAULT_MULT = 31'd16807;
   localparam logic [CNT_W-1:0]  INIT_LAST    = CNT_W'(INIT_STEPS - 1);

   // Width of one index bucket over the range of the generator.
   localparam logic [31:0] INDEX_DIV = 32'(64'd1 + (64'h7FFF_FFFE / 64'(TABLE_SIZE)));

   typedef struct packed {
      logic              mode;
      logic [DATA_W-1:0] seed;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] generator_state;
   } rsp_type;

   // Table slot picked by a previous output: x / INDEX_DIV, saturated.
   function automatic logic [IDX_W-1:0] index_of(input logic [DATA_W-1:0] x);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int k = 1; k < TABLE_SIZE; k++) begin
         if ({1'b0, x} >= 32'(k) * INDEX_DIV) begin
            r = IDX_W'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] fix_seed(input logic [DATA_W-1:0] s);
      logic [DATA_W-1:0] r;
      r = s;
      if (s == '0 || s == MODULUS) begin
         r = DATA_W'(1);
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] fix_mult(input logic [DATA_W-1:0] a);
      logic [DATA_W-1:0] r;
      r = a;
      if (a == '0 || a == MODULUS) begin
         r = DEFAULT_MULT;
      end
      return r;
   endfunction

endpackage

// ===== src/slrg_mulmod.sv =====
`timescale 1ns / 1ps

// Registered 31x31 product, folded modulo 2^31-1 on the way out.
module slrg_mulmod (
   input  logic                       clock,
   input  logic [slrg_pkg::DATA_W-1:0] operand_a,
   input  logic [slrg_pkg::DATA_W-1:0] operand_x,
   output logic [slrg_pkg::DATA_W-1:0] result
);
   import slrg_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [DATA_W:0]   fold1;
   logic [DATA_W:0]   fold2;

   assign prod_in = {{DATA_W{1'b0}}, operand_a} * {{DATA_W{1'b0}}, operand_x};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      fold1  = {1'b0, prod_ff[PROD_W-1:DATA_W]} + {1'b0, prod_ff[DATA_W-1:0]};
      fold2  = {1'b0, fold1[DATA_W-1:0]} + {{DATA_W{1'b0}}, fold1[DATA_W]};
      result = (fold2[DATA_W-1:0] == MODULUS) ? '0 : fold2[DATA_W-1:0];
   end

endmodule

// ===== src/shuffled_lcg_random_generator.sv =====
// Shuffled multiplicative congruential random generator.
// req channel: valid/ready; req_data.mode = 0 draws, 1 reseeds from req_data.seed and
// draws. rsp channel: valid/ready; one transaction per request, carrying the shuffled
// value and the generator state after the step.
// csr port: csr_write_enable loads csr_write_data into the multiplier; write only while
// the block is idle.
// Draws: an accepted plain draw moves to ST_DRAW, which puts the result in the output
// register once that register is free and returns to idle; a new request is taken only
// after the last one is through. The shuffle memory read is registered: the entry picked
// by the previous output is read into rd_ff and written back with the new state.
// A reseed, or the first draw after reset, first runs TABLE_SIZE + WARMUP_STEPS
// generator steps through the one multiplier and its modular fold, each step passing
// ST_INIT_MUL and ST_INIT_RED, and fills the table as it goes.
// Reset clears the generator to uninitialized and the multiplier to 16807; the table
// is not cleared, since it is always filled before it is read.
// When the receiver stalls, the result holds in the output register; one more request
// is accepted and waits in its final step until the output register frees up.
`timescale 1ns / 1ps

module shuffled_lcg_random_generator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  slrg_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output slrg_pkg::rsp_type           rsp_data,
   input  logic                        csr_write_enable,
   input  logic [slrg_pkg::DATA_W-1:0] csr_write_data
);
   import slrg_pkg::*;

   `include "shuffled_lcg_random_generator_assert.svh"

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_INIT_MUL = 5'b00010,
      ST_INIT_RED = 5'b00100,
      ST_PREP     = 5'b01000,
      ST_DRAW     = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] lcg_ff, lcg_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              init_ff, init_in;
   logic [DATA_W-1:0] mult_ff, mult_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0] shuffle_mem [TABLE_SIZE];
   logic [DATA_W-1:0] rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;

   logic [DATA_W-1:0] mult_src;
   logic [DATA_W-1:0] mul_result;
   logic              draw_fire;

   // a write in the accept cycle must reach the product started at that edge
   assign mult_src = csr_write_enable ? csr_write_data : mult_ff;
   assign mult_in  = csr_write_enable ? csr_write_data : mult_ff;

   slrg_mulmod u_mulmod (
      .clock     (clock),
      .operand_a (fix_mult(mult_src)),
      .operand_x (lcg_ff),
      .result    (mul_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign draw_fire = (state_ff == ST_DRAW) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lcg_in       = lcg_ff;
      idx_in       = idx_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode || !init_ff) begin
                  lcg_in   = req_data.mode ? fix_seed(req_data.seed) : DATA_W'(1);
                  cnt_in   = INIT_LAST;
                  state_in = ST_INIT_MUL;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_INIT_MUL: begin
            state_in = ST_INIT_RED;
         end
         ST_INIT_RED: begin
            lcg_in = mul_result;
            if (cnt_ff < CNT_W'(TABLE_SIZE)) begin
               mem_we    = 1'b1;
               mem_waddr = cnt_ff[IDX_W-1:0];
            end
            if (cnt_ff == '0) begin
               idx_in   = index_of(mul_result);
               init_in  = 1'b1;
               state_in = ST_PREP;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_INIT_MUL;
            end
         end
         ST_PREP: begin
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (draw_fire) begin
               lcg_in                      = mul_result;
               mem_we                      = 1'b1;
               mem_waddr                   = idx_ff;
               rsp_valid_in                = 1'b1;
               rsp_data_in.value           = rd_ff;
               rsp_data_in.generator_state = mul_result;
               idx_in                      = index_of(rd_ff);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         lcg_ff       <= '0;
         idx_ff       <= '0;
         init_ff      <= 1'b0;
         mult_ff      <= DEFAULT_MULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lcg_ff       <= lcg_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         mult_ff      <= mult_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shuffle_mem[mem_waddr] <= mul_result;
      end
      rd_ff <= shuffle_mem[idx_ff];
   end

   `SLRG_ASSERT(a_draw_needs_init, (state_ff == ST_DRAW) |-> init_ff, "draw before table fill")
   `SLRG_ASSERT(a_init_sticky, init_ff |=> init_ff, "generator lost its initialization")
   `SLRG_ASSERT(a_accept_busy, (req_valid && req_ready) |=> (state_ff != ST_IDLE), "transaction dropped")
   `SLRG_ASSERT(a_state_nonzero, rsp_valid_ff |-> (rsp_data_ff.generator_state != '0), "zero state")
   `SLRG_ASSERT_ALWAYS(a_idx_range, int'(idx_ff) < TABLE_SIZE, "table index out of range")

endmodule
